@@ rtl/two_level_scheduler_with_aging_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the two-level scheduler
// Shared property forms, clocked on i_clk and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef TWO_LEVEL_SCHEDULER_WITH_AGING_MACROS_SVH
`define TWO_LEVEL_SCHEDULER_WITH_AGING_MACROS_SVH

// same-cycle implication
`define TLSA_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define TLSA_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/tlsa_pkg.sv @@
// ----------------------------------------------------------------------------
// tlsa_pkg
// Types, codes and constants of the two-level scheduler with aging.
// ----------------------------------------------------------------------------
package tlsa_pkg;

    localparam int DEF_QUEUE_DEPTH = 16;
    localparam logic [3:0] MAX_AGE_RST = 4'd5;
    localparam logic [3:0] AGE_MAX = 4'd15;
    localparam logic [15:0] DEFUNCT_MAX = 16'hFFFF;

    localparam logic [2:0] CMD_ADD  = 3'd0;
    localparam logic [2:0] CMD_SELH = 3'd1;
    localparam logic [2:0] CMD_SELL = 3'd2;
    localparam logic [2:0] CMD_TICK = 3'd3;
    localparam logic [2:0] CMD_EXIT = 3'd4;
    localparam logic [2:0] CMD_TERM = 3'd5;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_EMPTY     = 2'd1;
    localparam logic [1:0] ST_FULL      = 2'd2;
    localparam logic [1:0] ST_NOT_FOUND = 2'd3;

    localparam logic QSEL_HIGH = 1'b0;
    localparam logic QSEL_LOW  = 1'b1;

    typedef struct packed {
        logic [2:0]  cmd;
        logic [15:0] task_id;
        logic        low_priority;
        logic        critical;
        logic [7:0]  exit_status;
    } t_req;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] chosen_id;
        logic        chosen_critical;
        logic        chosen_low_origin;
        logic [4:0]  high_count;
        logic [4:0]  low_count;
        logic [15:0] defunct_count;
        logic [4:0]  promoted_count;
    } t_rsp;

    typedef struct packed {
        logic [15:0] pid;
        logic        crit;
        logic        lowo;
        logic [3:0]  age;
    } t_entry;

    typedef struct packed {
        logic   active;
        logic   found;
        t_entry entry;
    } t_tok;

    typedef enum logic [1:0] {Q_IDLE, Q_LOAD, Q_AGE, Q_PACK} t_qop;

    typedef enum logic [1:0] {W_CRIT, W_ANY, W_PID, W_OLD} t_wmode;

    typedef struct packed {
        t_qop        op;
        logic        inject;
        t_wmode      mode;
        logic [15:0] key;
        logic [3:0]  max_age;
        t_entry      load;
    } t_qctl;

    typedef enum logic [2:0] {
        S_IDLE, S_LOAD, S_AGE, S_WALK, S_PACK, S_FIN
    } t_state;

endpackage

@@ rtl/tlsa_cell.sv @@
// ----------------------------------------------------------------------------
// tlsa_cell
// One queue slot: holds an entry, takes part in search tokens, aging and
// gap closing with its neighbors.
// ----------------------------------------------------------------------------
module tlsa_cell import tlsa_pkg::*; #(
    parameter int IDX = 0,
    parameter int CW  = 5
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_qctl         i_ctl,
    input  logic [CW-1:0] i_fill,
    input  t_tok          i_tok,
    input  logic          i_prev_valid,
    input  logic          i_next_valid,
    input  t_entry        i_next_entry,
    output logic          o_valid,
    output t_entry        o_entry,
    output t_tok          o_tok
);

    logic   r_valid, n_valid;
    t_entry r_entry, n_entry;
    t_tok   r_tok, n_tok;
    logic   w_pred, w_hit;

    always_comb begin
        unique case (i_ctl.mode)
            W_CRIT:  w_pred = r_entry.crit;
            W_ANY:   w_pred = 1'b1;
            W_PID:   w_pred = (r_entry.pid == i_ctl.key);
            W_OLD:   w_pred = (r_entry.age >= i_ctl.max_age);
            default: w_pred = 1'b0;
        endcase
    end

    assign w_hit = i_tok.active && !i_tok.found && r_valid && w_pred;

    always_comb begin
        n_tok = i_tok;
        if (w_hit) begin
            n_tok.found = 1'b1;
            n_tok.entry = r_entry;
        end
    end

    always_comb begin
        n_valid = r_valid;
        n_entry = r_entry;
        if (w_hit) begin
            n_valid = 1'b0;
        end
        unique case (i_ctl.op)
            Q_LOAD: begin
                if (i_fill == CW'(IDX)) begin
                    n_valid = 1'b1;
                    n_entry = i_ctl.load;
                end
            end
            Q_AGE: begin
                if (r_valid && r_entry.age != AGE_MAX) begin
                    n_entry.age = r_entry.age + 4'd1;
                end
            end
            Q_PACK: begin
                if (!r_valid && i_next_valid) begin
                    n_valid = 1'b1;
                    n_entry = i_next_entry;
                end else if (r_valid && !i_prev_valid) begin
                    n_valid = 1'b0;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_tok   <= '0;
        end else begin
            r_valid <= n_valid;
            r_tok   <= n_tok;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

    assign o_valid = r_valid;
    assign o_entry = r_entry;
    assign o_tok   = r_tok;

endmodule

@@ rtl/tlsa_queue.sv @@
// ----------------------------------------------------------------------------
// tlsa_queue
// Row of slot cells forming one ready queue; search tokens enter at the
// head and leave at the far end.
// ----------------------------------------------------------------------------
module tlsa_queue import tlsa_pkg::*; #(
    parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH,
    parameter int CW          = $clog2(QUEUE_DEPTH + 1)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_qctl         i_ctl,
    input  logic [CW-1:0] i_fill,
    output t_tok          o_tok
);

    logic   w_valid [QUEUE_DEPTH];
    t_entry w_entry [QUEUE_DEPTH];
    t_tok   w_tok   [QUEUE_DEPTH];
    t_tok   w_head_tok;

    always_comb begin
        w_head_tok        = '0;
        w_head_tok.active = i_ctl.inject;
    end

    for (genvar gi = 0; gi < QUEUE_DEPTH; gi++) begin : g_cell
        t_tok   w_tin;
        logic   w_pv;
        logic   w_nv;
        t_entry w_ne;

        if (gi == 0) begin : g_head
            assign w_tin = w_head_tok;
            assign w_pv  = 1'b1;
        end else begin : g_body
            assign w_tin = w_tok[gi-1];
            assign w_pv  = w_valid[gi-1];
        end

        if (gi == QUEUE_DEPTH - 1) begin : g_tail
            assign w_nv = 1'b0;
            assign w_ne = '0;
        end else begin : g_mid
            assign w_nv = w_valid[gi+1];
            assign w_ne = w_entry[gi+1];
        end

        tlsa_cell #(
            .IDX (gi),
            .CW  (CW)
        ) u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctl        (i_ctl),
            .i_fill       (i_fill),
            .i_tok        (w_tin),
            .i_prev_valid (w_pv),
            .i_next_valid (w_nv),
            .i_next_entry (w_ne),
            .o_valid      (w_valid[gi]),
            .o_entry      (w_entry[gi]),
            .o_tok        (w_tok[gi])
        );
    end

    assign o_tok = w_tok[QUEUE_DEPTH-1];

endmodule

@@ rtl/two_level_scheduler_with_aging.sv @@
// ----------------------------------------------------------------------------
// two_level_scheduler_with_aging
// High and low ready queues of tasks with selection, termination by pid
// and promotion of aged low entries.
// ----------------------------------------------------------------------------
//  channel   | handshake            | payload
//  request   | start / busy         | i_req (t_req)
//  result    | o_done strobe        | o_rsp (t_rsp)
//  config    | i_cfg_we             | i_cfg_wdata (max_age)
//
//  Add loads the new entry into its queue; an add to a full queue, exit and
//  unknown commands go straight to the result.
//  Selects and terminate walk a token down the cell row (at most two walks)
//  and then close the gap if an entry was taken.
//  Tick ages the low queue, walks it for aged entries, walking again after each
//  promotion, then closes the gap; the last walk is skipped once the high queue fills.
//  Reset clears queues, counts and max_age (to 5); no clearing pass.
//  Results cannot be stalled; busy holds off requests until o_done.
// ----------------------------------------------------------------------------
module two_level_scheduler_with_aging import tlsa_pkg::*; #(
    parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       start,
    output logic       busy,
    input  t_req       i_req,
    output logic       o_done,
    output t_rsp       o_rsp,
    input  logic       i_cfg_we,
    input  logic [3:0] i_cfg_wdata
);

    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(QUEUE_DEPTH);
    localparam logic [CW-1:0] DEPTH_M1 = CW'(QUEUE_DEPTH - 1);

    t_state        r_state, n_state;
    logic [CW-1:0] r_cnt, n_cnt;
    logic [2:0]    r_cmd, n_cmd;
    logic [15:0]   r_pid, n_pid;
    logic          r_lowp, n_lowp;
    logic          r_crit, n_crit;
    logic [3:0]    r_max_age;
    logic [CW-1:0] r_high_fill, n_high_fill;
    logic [CW-1:0] r_low_fill, n_low_fill;
    logic [15:0]   r_defunct, n_defunct;
    logic [1:0]    r_status, n_status;
    t_entry        r_pick, n_pick;
    logic          r_picked, n_picked;
    logic [CW-1:0] r_promoted, n_promoted;
    logic          r_walk_q, n_walk_q;
    t_wmode        r_mode, n_mode;
    logic          r_done;
    t_rsp          r_rsp, n_rsp;

    t_qctl w_hctl, w_lctl;
    t_tok  w_htok, w_ltok, w_tok;
    logic  w_add_full, w_walk_end, w_pack_end;
    logic [15:0] w_defunct_inc;

    assign w_tok      = (r_walk_q == QSEL_LOW) ? w_ltok : w_htok;
    assign w_walk_end = (r_cnt == DEPTH_C);
    assign w_pack_end = (r_cnt == DEPTH_M1);
    assign w_add_full = i_req.low_priority ? (r_low_fill == DEPTH_C)
                                           : (r_high_fill == DEPTH_C);
    assign w_defunct_inc = (r_defunct != DEFUNCT_MAX) ? r_defunct + 16'd1 : r_defunct;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    case (i_req.cmd)
                        CMD_ADD:  n_state = w_add_full ? S_FIN : S_LOAD;
                        CMD_SELH: n_state = (r_high_fill == '0) ? S_FIN : S_WALK;
                        CMD_SELL: n_state = (r_low_fill == '0) ? S_FIN : S_WALK;
                        CMD_TICK: n_state = S_AGE;
                        CMD_TERM: n_state = S_WALK;
                        default:  n_state = S_FIN;
                    endcase
                end
            end
            S_LOAD: begin
                if (r_cmd == CMD_TICK) begin
                    n_state = (r_high_fill == DEPTH_M1) ? S_PACK : S_WALK;
                end else begin
                    n_state = S_FIN;
                end
            end
            S_AGE: n_state = (r_high_fill == DEPTH_C) ? S_PACK : S_WALK;
            S_WALK: begin
                if (w_walk_end) begin
                    case (r_cmd)
                        CMD_SELH: n_state = w_tok.found ? S_PACK : S_WALK;
                        CMD_SELL: n_state = S_PACK;
                        CMD_TERM: begin
                            if (w_tok.found) begin
                                n_state = S_PACK;
                            end else begin
                                n_state = (r_walk_q == QSEL_HIGH) ? S_WALK : S_FIN;
                            end
                        end
                        CMD_TICK: n_state = w_tok.found ? S_LOAD : S_PACK;
                        default:  n_state = S_FIN;
                    endcase
                end
            end
            S_PACK: begin
                if (w_pack_end) begin
                    n_state = S_FIN;
                end
            end
            S_FIN:   n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // datapath next values
    always_comb begin
        n_cnt       = '0;
        n_cmd       = r_cmd;
        n_pid       = r_pid;
        n_lowp      = r_lowp;
        n_crit      = r_crit;
        n_high_fill = r_high_fill;
        n_low_fill  = r_low_fill;
        n_defunct   = r_defunct;
        n_status    = r_status;
        n_pick      = r_pick;
        n_picked    = r_picked;
        n_promoted  = r_promoted;
        n_walk_q    = r_walk_q;
        n_mode      = r_mode;
        n_rsp       = r_rsp;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_cmd      = i_req.cmd;
                    n_pid      = i_req.task_id;
                    n_lowp     = i_req.low_priority;
                    n_crit     = i_req.critical;
                    n_status   = ST_OK;
                    n_picked   = 1'b0;
                    n_promoted = '0;
                    case (i_req.cmd)
                        CMD_ADD: begin
                            if (w_add_full) begin
                                n_status = ST_FULL;
                            end
                        end
                        CMD_SELH: begin
                            n_walk_q = QSEL_HIGH;
                            n_mode   = W_CRIT;
                            if (r_high_fill == '0) begin
                                n_status = ST_EMPTY;
                            end
                        end
                        CMD_SELL: begin
                            n_walk_q = QSEL_LOW;
                            n_mode   = W_ANY;
                            if (r_low_fill == '0) begin
                                n_status = ST_EMPTY;
                            end
                        end
                        CMD_TICK: begin
                            n_walk_q = QSEL_LOW;
                            n_mode   = W_OLD;
                        end
                        CMD_EXIT: n_defunct = w_defunct_inc;
                        CMD_TERM: begin
                            n_walk_q = QSEL_HIGH;
                            n_mode   = W_PID;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_LOAD: begin
                if (r_cmd == CMD_TICK) begin
                    n_high_fill = r_high_fill + 1'b1;
                    n_promoted  = r_promoted + 1'b1;
                end else if (r_lowp) begin
                    n_low_fill = r_low_fill + 1'b1;
                end else begin
                    n_high_fill = r_high_fill + 1'b1;
                end
            end
            S_WALK: begin
                if (!w_walk_end) begin
                    n_cnt = r_cnt + 1'b1;
                end else begin
                    case (r_cmd)
                        CMD_SELH: begin
                            if (w_tok.found) begin
                                n_pick      = w_tok.entry;
                                n_picked    = 1'b1;
                                n_high_fill = r_high_fill - 1'b1;
                            end else begin
                                n_mode = W_ANY;
                            end
                        end
                        CMD_SELL: begin
                            n_pick     = w_tok.entry;
                            n_picked   = 1'b1;
                            n_low_fill = r_low_fill - 1'b1;
                        end
                        CMD_TERM: begin
                            if (w_tok.found) begin
                                n_defunct = w_defunct_inc;
                                if (r_walk_q == QSEL_HIGH) begin
                                    n_high_fill = r_high_fill - 1'b1;
                                end else begin
                                    n_low_fill = r_low_fill - 1'b1;
                                end
                            end else if (r_walk_q == QSEL_HIGH) begin
                                n_walk_q = QSEL_LOW;
                            end else begin
                                n_status = ST_NOT_FOUND;
                            end
                        end
                        CMD_TICK: begin
                            if (w_tok.found) begin
                                n_pick     = w_tok.entry;
                                n_low_fill = r_low_fill - 1'b1;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_PACK: begin
                if (!w_pack_end) begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_FIN: begin
                n_rsp.status            = r_status;
                n_rsp.chosen_id         = r_picked ? r_pick.pid : 16'd0;
                n_rsp.chosen_critical   = r_picked && r_pick.crit;
                n_rsp.chosen_low_origin = r_picked && r_pick.lowo;
                n_rsp.high_count        = 5'(r_high_fill);
                n_rsp.low_count         = 5'(r_low_fill);
                n_rsp.defunct_count     = r_defunct;
                n_rsp.promoted_count    = 5'(r_promoted);
            end
            default: begin
            end
        endcase
    end

    // queue controls
    always_comb begin
        w_hctl         = '0;
        w_hctl.op      = Q_IDLE;
        w_hctl.mode    = r_mode;
        w_hctl.key     = r_pid;
        w_hctl.max_age = r_max_age;
        if (r_cmd == CMD_TICK) begin
            w_hctl.load = '{pid: r_pick.pid, crit: r_pick.crit, lowo: r_pick.lowo,
                            age: 4'd0};
        end else begin
            w_hctl.load = '{pid: r_pid, crit: r_crit, lowo: r_lowp, age: 4'd0};
        end
        w_lctl = w_hctl;
        unique case (r_state)
            S_LOAD: begin
                if (r_cmd != CMD_TICK && r_lowp) begin
                    w_lctl.op = Q_LOAD;
                end else begin
                    w_hctl.op = Q_LOAD;
                end
            end
            S_AGE: w_lctl.op = Q_AGE;
            S_WALK: begin
                if (r_walk_q == QSEL_LOW) begin
                    w_lctl.inject = (r_cnt == '0);
                end else begin
                    w_hctl.inject = (r_cnt == '0);
                end
            end
            S_PACK: begin
                if (r_walk_q == QSEL_LOW) begin
                    w_lctl.op = Q_PACK;
                end else begin
                    w_hctl.op = Q_PACK;
                end
            end
            default: begin
            end
        endcase
    end

    tlsa_queue #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .CW          (CW)
    ) u_high (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_hctl),
        .i_fill  (r_high_fill),
        .o_tok   (w_htok)
    );

    tlsa_queue #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .CW          (CW)
    ) u_low (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_lctl),
        .i_fill  (r_low_fill),
        .o_tok   (w_ltok)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_high_fill <= '0;
            r_low_fill  <= '0;
            r_defunct   <= '0;
            r_max_age   <= MAX_AGE_RST;
            r_done      <= 1'b0;
            r_cmd       <= CMD_ADD;
            r_walk_q    <= QSEL_HIGH;
            r_mode      <= W_ANY;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_high_fill <= n_high_fill;
            r_low_fill  <= n_low_fill;
            r_defunct   <= n_defunct;
            r_done      <= (r_state == S_FIN);
            r_cmd       <= n_cmd;
            r_walk_q    <= n_walk_q;
            r_mode      <= n_mode;
            if (i_cfg_we) begin
                r_max_age <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_pid      <= n_pid;
        r_lowp     <= n_lowp;
        r_crit     <= n_crit;
        r_status   <= n_status;
        r_pick     <= n_pick;
        r_picked   <= n_picked;
        r_promoted <= n_promoted;
        r_rsp      <= n_rsp;
    end

    assign busy   = (r_state != S_IDLE);
    assign o_done = r_done;
    assign o_rsp  = r_rsp;

endmodule

@@ rtl/tlsa_chk.sv @@
// ----------------------------------------------------------------------------
// tlsa_chk
// Port-level checks of the scheduler handshake and result fields.
// ----------------------------------------------------------------------------
`include "two_level_scheduler_with_aging_macros.svh"

module tlsa_chk import tlsa_pkg::*; #(
    parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH
) (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       start,
    input logic       busy,
    input t_req       i_req,
    input logic       o_done,
    input t_rsp       o_rsp,
    input logic       i_cfg_we,
    input logic [3:0] i_cfg_wdata
);

    `TLSA_ASSERT_NXT(a_start_busy, start && !busy, busy, "accepted request did not raise busy")
    `TLSA_ASSERT_IMP(a_done_idle, o_done, !busy && $past(busy), "result without prior work")
    `TLSA_ASSERT_NXT(a_done_once, o_done, !o_done, "result strobe longer than one cycle")
    `TLSA_ASSERT_IMP(a_empty_zero, o_done && o_rsp.status == ST_EMPTY,
        o_rsp.chosen_id == 16'd0 && !o_rsp.chosen_critical, "empty select reported a task")
    `TLSA_ASSERT_IMP(a_count_max, o_done,
        o_rsp.promoted_count <= 5'(QUEUE_DEPTH) || QUEUE_DEPTH > 31, "promoted count too big")

endmodule

bind two_level_scheduler_with_aging tlsa_chk #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_chk (.*);

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives requests into the two-level scheduler, predicts each result from
// a queue model kept in the bench and compares every field. Covers adds,
// both selects, aging ticks across several max_age settings, exit and
// terminate, full and empty queues, and unknown commands.
// ----------------------------------------------------------------------------
module tb_top;
    import tlsa_pkg::*;

    localparam int DEPTH = 16;

    typedef struct {
        logic [15:0] pid;
        logic        crit;
        logic        lowo;
        logic [3:0]  age;
    } t_task;

    logic       i_clk;
    logic       i_rst_n;
    logic       start;
    logic       busy;
    t_req       i_req;
    logic       o_done;
    t_rsp       o_rsp;
    logic       i_cfg_we;
    logic [3:0] i_cfg_wdata;

    t_task       high_q[$];
    t_task       low_q[$];
    logic [15:0] defunct_total;
    logic [3:0]  age_limit;
    t_rsp        pending_rsp[$];
    int          mismatches;
    int          requests_sent;
    int          results_seen;
    int          promotions_seen;
    bit          no_idle;

    two_level_scheduler_with_aging dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_req      (i_req),
        .o_done     (o_done),
        .o_rsp      (o_rsp),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #20000000;
        $display("TB_ERROR");
        $finish;
    end

    function automatic t_rsp schedule_step(t_req r);
        t_rsp  s;
        t_task e;
        t_task kept[$];
        int    pos;
        s = '0;
        s.status = ST_OK;
        case (r.cmd)
            CMD_ADD: begin
                e.pid = r.task_id;
                e.crit = r.critical;
                e.lowo = r.low_priority;
                e.age = 4'd0;
                if (r.low_priority) begin
                    if (low_q.size() >= DEPTH) s.status = ST_FULL;
                    else low_q.push_back(e);
                end else begin
                    if (high_q.size() >= DEPTH) s.status = ST_FULL;
                    else high_q.push_back(e);
                end
            end
            CMD_SELH: begin
                if (high_q.size() == 0) begin
                    s.status = ST_EMPTY;
                end else begin
                    pos = 0;
                    foreach (high_q[i]) begin
                        if (high_q[i].crit) begin
                            pos = i;
                            break;
                        end
                    end
                    s.chosen_id = high_q[pos].pid;
                    s.chosen_critical = high_q[pos].crit;
                    s.chosen_low_origin = high_q[pos].lowo;
                    high_q.delete(pos);
                end
            end
            CMD_SELL: begin
                if (low_q.size() == 0) begin
                    s.status = ST_EMPTY;
                end else begin
                    s.chosen_id = low_q[0].pid;
                    s.chosen_critical = low_q[0].crit;
                    s.chosen_low_origin = low_q[0].lowo;
                    low_q.delete(0);
                end
            end
            CMD_TICK: begin
                foreach (low_q[i]) begin
                    e = low_q[i];
                    if (e.age < AGE_MAX) e.age = e.age + 4'd1;
                    if (e.age >= age_limit && high_q.size() < DEPTH) begin
                        e.age = 4'd0;
                        high_q.push_back(e);
                        s.promoted_count = s.promoted_count + 5'd1;
                    end else begin
                        kept.push_back(e);
                    end
                end
                low_q = kept;
            end
            CMD_EXIT: begin
                if (defunct_total != DEFUNCT_MAX) defunct_total++;
            end
            CMD_TERM: begin
                pos = -1;
                foreach (high_q[i]) begin
                    if (pos < 0 && high_q[i].pid == r.task_id) pos = i;
                end
                if (pos >= 0) begin
                    high_q.delete(pos);
                end else begin
                    foreach (low_q[i]) begin
                        if (pos < 0 && low_q[i].pid == r.task_id) pos = i;
                    end
                    if (pos >= 0) low_q.delete(pos);
                end
                if (pos < 0) s.status = ST_NOT_FOUND;
                else if (defunct_total != DEFUNCT_MAX) defunct_total++;
            end
            default: ;
        endcase
        s.high_count = 5'(high_q.size());
        s.low_count = 5'(low_q.size());
        s.defunct_count = defunct_total;
        return s;
    endfunction

    always @(posedge i_clk) begin
        t_rsp want;
        if (i_rst_n && o_done) begin
            results_seen++;
            promotions_seen += o_rsp.promoted_count;
            if (pending_rsp.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %h", o_rsp);
            end else begin
                want = pending_rsp.pop_front();
                if (o_rsp !== want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"mismatch: st %0d/%0d id %h/%h cr %b/%b lo %b/%b",
                                  " hc %0d/%0d lc %0d/%0d df %0d/%0d pr %0d/%0d"},
                            want.status, o_rsp.status, want.chosen_id, o_rsp.chosen_id,
                            want.chosen_critical, o_rsp.chosen_critical,
                            want.chosen_low_origin, o_rsp.chosen_low_origin,
                            want.high_count, o_rsp.high_count, want.low_count, o_rsp.low_count,
                            want.defunct_count, o_rsp.defunct_count,
                            want.promoted_count, o_rsp.promoted_count);
                end
            end
        end
    end

    task automatic send_request(t_req r);
        while (!no_idle && $urandom_range(99) < 27) @(posedge i_clk);
        start <= 1'b1;
        i_req <= r;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        pending_rsp.push_back(schedule_step(r));
        requests_sent++;
        start <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic send_cmd(logic [2:0] c, logic [15:0] id, logic lp, logic cr);
        t_req r;
        r.cmd = c;
        r.task_id = id;
        r.low_priority = lp;
        r.critical = cr;
        r.exit_status = 8'($urandom);
        send_request(r);
    endtask

    task automatic drain_results();
        int guard;
        guard = 0;
        while (pending_rsp.size() != 0 && guard < 100000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (120) @(posedge i_clk);
    endtask

    task automatic write_max_age(logic [3:0] v);
        drain_results();
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        age_limit = v;
        @(posedge i_clk);
    endtask

    task automatic test_directed();
        send_cmd(CMD_SELH, 16'h0000, 1'b0, 1'b0);
        send_cmd(CMD_SELL, 16'hFFFF, 1'b1, 1'b1);
        send_cmd(CMD_TICK, 16'h0000, 1'b0, 1'b0);
        send_cmd(CMD_TERM, 16'hFFFF, 1'b0, 1'b0);
        send_cmd(CMD_ADD, 16'hFFFF, 1'b0, 1'b0);
        send_cmd(CMD_ADD, 16'h0000, 1'b0, 1'b1);
        send_cmd(CMD_ADD, 16'h1234, 1'b1, 1'b1);
        send_cmd(CMD_ADD, 16'hFFFF, 1'b1, 1'b0);
        send_cmd(CMD_SELH, 16'h0000, 1'b0, 1'b0);
        send_cmd(CMD_TERM, 16'hFFFF, 1'b0, 1'b0);
        send_cmd(CMD_TERM, 16'hFFFF, 1'b0, 1'b0);
        send_cmd(CMD_EXIT, 16'hAAAA, 1'b1, 1'b1);
        send_cmd(3'd6, 16'h5555, 1'b1, 1'b0);
        send_cmd(3'd7, 16'h0001, 1'b0, 1'b1);
        repeat (5) send_cmd(CMD_TICK, 16'h0000, 1'b0, 1'b0);
        send_cmd(CMD_SELL, 16'h0000, 1'b0, 1'b0);
        send_cmd(CMD_SELH, 16'h0000, 1'b0, 1'b0);
    endtask

    task automatic test_full_queues();
        repeat (DEPTH + 1) send_cmd(CMD_ADD, 16'($urandom), 1'b0, 1'($urandom));
        repeat (DEPTH + 1) send_cmd(CMD_ADD, 16'($urandom), 1'b1, 1'($urandom));
        repeat (2) send_cmd(CMD_TICK, 16'h0000, 1'b0, 1'b0);
        repeat (DEPTH + 1) send_cmd(CMD_SELH, 16'h0000, 1'b0, 1'b0);
        repeat (DEPTH + 1) send_cmd(CMD_TICK, 16'h0000, 1'b0, 1'b0);
        repeat (DEPTH + 1) send_cmd(CMD_SELH, 16'h0000, 1'b0, 1'b0);
    endtask

    task automatic random_phase(int count);
        logic [15:0] id;
        int          pick;
        repeat (count) begin
            pick = $urandom_range(99);
            if (pick < 30) begin
                send_cmd(CMD_ADD, 16'($urandom_range(31)), 1'($urandom), 1'($urandom));
            end else if (pick < 42) begin
                send_cmd(CMD_SELH, 16'($urandom), 1'($urandom), 1'($urandom));
            end else if (pick < 52) begin
                send_cmd(CMD_SELL, 16'($urandom), 1'($urandom), 1'($urandom));
            end else if (pick < 72) begin
                send_cmd(CMD_TICK, 16'($urandom), 1'($urandom), 1'($urandom));
            end else if (pick < 78) begin
                send_cmd(CMD_EXIT, 16'($urandom), 1'($urandom), 1'($urandom));
            end else if (pick < 96) begin
                id = (pick < 90) ? 16'($urandom_range(31)) : 16'($urandom);
                send_cmd(CMD_TERM, id, 1'($urandom), 1'($urandom));
            end else if (pick < 98) begin
                send_cmd(CMD_ADD, 16'($urandom), 1'($urandom), 1'($urandom));
            end else begin
                send_cmd(3'($urandom_range(7, 6)), 16'($urandom), 1'($urandom),
                    1'($urandom));
            end
        end
    endtask

    task automatic test_random_aging();
        logic [3:0] settings[6] = '{4'd1, 4'd15, 4'd0, 4'd3, 4'd8, 4'd5};
        foreach (settings[i]) begin
            write_max_age(settings[i]);
            no_idle = (i == 2);
            random_phase(275);
        end
        no_idle = 1'b0;
    endtask

    initial begin
        i_rst_n = 1'b0;
        start = 1'b0;
        i_req = '0;
        i_cfg_we = 1'b0;
        i_cfg_wdata = 4'd0;
        defunct_total = 16'd0;
        age_limit = MAX_AGE_RST;
        mismatches = 0;
        requests_sent = 0;
        results_seen = 0;
        promotions_seen = 0;
        no_idle = 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_full_queues();
        write_max_age(4'd2);
        test_full_queues();
        test_random_aging();
        drain_results();
        $display("ran %0d requests, %0d results, %0d promotions, max_age 0..15",
            requests_sent, results_seen, promotions_seen);
        if (mismatches == 0 && pending_rsp.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end
endmodule
